// ----- hw/rtl/ymodem_packet_receiver_assert.svh -----
// Assertion macros used by the YMODEM receiver checker
`ifndef YMODEM_PACKET_RECEIVER_ASSERT_SVH
`define YMODEM_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define YMP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ymodem receiver check failed");

// next-cycle implication
`define YMP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ymodem receiver check failed");

`endif

// ----- hw/rtl/ymp_pkg.sv -----
// Types, codes and the CRC-16/XMODEM byte update for the YMODEM receiver
package ymp_pkg;

	typedef enum logic [6:0] {
		PH_HEADER  = 7'b0000001,
		PH_CANCEL2 = 7'b0000010,
		PH_SEQ     = 7'b0000100,
		PH_COMP    = 7'b0001000,
		PH_DATA    = 7'b0010000,
		PH_CRC_HI  = 7'b0100000,
		PH_CRC_LO  = 7'b1000000
	} phase_t;

	localparam logic [2:0] ST_GOOD   = 3'd0;
	localparam logic [2:0] ST_EOT    = 3'd1;
	localparam logic [2:0] ST_CANCEL = 3'd2;
	localparam logic [2:0] ST_ABORT  = 3'd3;
	localparam logic [2:0] ST_ERROR  = 3'd4;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [7:0] HDR_SOH     = 8'h01;
	localparam logic [7:0] HDR_STX     = 8'h02;
	localparam logic [7:0] HDR_EOT     = 8'h04;
	localparam logic [7:0] HDR_CA      = 8'h18;
	localparam logic [7:0] HDR_ABORT_U = 8'h41;
	localparam logic [7:0] HDR_ABORT_L = 8'h61;

	localparam logic [10:0] LEN_SHORT = 11'd128;
	localparam logic [10:0] LEN_LONG  = 11'd1024;

	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [2:0]  status;
		logic [7:0]  seq;
		logic [10:0] len;
	} result_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/ymp_in_stage.sv -----
// Input register stage of the YMODEM receiver
module ymp_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ymp_pkg::item_t in_item,
	output logic           item_valid,
	output ymp_pkg::item_t item,
	input  logic           item_take
);
	import ymp_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	assign in_ready   = !valid_s1 || item_take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- hw/rtl/ymp_framer.sv -----
// Packet framing state, CRC check, timeout and result register
module ymp_framer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  ymp_pkg::item_t   item,
	output logic             item_take,
	input  logic [15:0]      timeout,
	output logic             out_valid,
	input  logic             out_ready,
	output ymp_pkg::result_t result
);
	import ymp_pkg::*;

	phase_t      phase_q, phase_n;
	logic        long_q, long_n;
	logic [10:0] idx_q, idx_n;
	logic [7:0]  seq_q, seq_n;
	logic        comp_ok_q, comp_ok_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  crc_hi_q, crc_hi_n;
	logic [15:0] idle_q, idle_n;

	logic        valid_s2;
	result_t     res_s2;

	logic        advance;
	logic        emit;
	result_t     res_n;
	logic [15:0] idle_inc;
	logic [10:0] idx_inc;
	logic [10:0] plen;
	logic [7:0]  b;

	assign advance   = !valid_s2 || out_ready;
	assign item_take = item_valid && advance;
	assign out_valid = valid_s2;
	assign result    = res_s2;

	assign b        = item.rx_byte;
	assign idle_inc = idle_q + 16'd1;
	assign idx_inc  = idx_q + 11'd1;
	assign plen     = long_q ? LEN_LONG : LEN_SHORT;

	always_comb begin
		phase_n   = phase_q;
		long_n    = long_q;
		idx_n     = idx_q;
		seq_n     = seq_q;
		comp_ok_n = comp_ok_q;
		crc_n     = crc_q;
		crc_hi_n  = crc_hi_q;
		idle_n    = idle_q;
		emit      = 1'b0;
		res_n     = '0;
		res_n.kind = KIND_STATUS;
		if (item_take) begin
			if (item.action == ACT_TICK) begin
				if (idle_inc >= timeout) begin
					idle_n       = '0;
					emit         = 1'b1;
					res_n.status = ST_ERROR;
				end else begin
					idle_n = idle_inc;
				end
			end else begin
				idle_n = '0;
				case (phase_q)
					PH_HEADER: begin
						if (b == HDR_SOH || b == HDR_STX) begin
							long_n    = (b == HDR_STX);
							idx_n     = '0;
							crc_n     = '0;
							comp_ok_n = 1'b0;
							phase_n   = PH_SEQ;
						end else if (b == HDR_CA) begin
							phase_n = PH_CANCEL2;
						end else begin
							emit = 1'b1;
							if (b == HDR_EOT)
								res_n.status = ST_EOT;
							else if (b == HDR_ABORT_U || b == HDR_ABORT_L)
								res_n.status = ST_ABORT;
							else
								res_n.status = ST_ERROR;
						end
					end
					PH_CANCEL2: begin
						emit         = 1'b1;
						res_n.status = (b == HDR_CA) ? ST_CANCEL : ST_ERROR;
					end
					PH_SEQ: begin
						seq_n   = b;
						phase_n = PH_COMP;
					end
					PH_COMP: begin
						comp_ok_n = ((b ^ 8'hff) == seq_q);
						idx_n     = '0;
						phase_n   = PH_DATA;
					end
					PH_DATA: begin
						crc_n = crc_step(crc_q, b);
						idx_n = idx_inc;
						if (idx_inc >= plen)
							phase_n = PH_CRC_HI;
					end
					PH_CRC_HI: begin
						crc_hi_n = b;
						phase_n  = PH_CRC_LO;
					end
					PH_CRC_LO: begin
						emit = 1'b1;
						if (comp_ok_q && ({crc_hi_q, b} == crc_q)) begin
							res_n.status = ST_GOOD;
							res_n.seq    = seq_q;
							res_n.len    = plen;
						end else begin
							res_n.status = ST_ERROR;
						end
					end
					default: begin
						phase_n = PH_HEADER;
						idx_n   = '0;
					end
				endcase
			end
			// every status closes the packet
			if (emit) begin
				phase_n = PH_HEADER;
				idx_n   = '0;
			end
		end
		// payload byte result
		if (item_take && item.action == ACT_BYTE && phase_q == PH_DATA) begin
			emit       = 1'b1;
			res_n      = '0;
			res_n.kind = KIND_DATA;
			res_n.data = b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			long_q    <= 1'b0;
			idx_q     <= '0;
			seq_q     <= '0;
			comp_ok_q <= 1'b0;
			crc_q     <= '0;
			crc_hi_q  <= '0;
			idle_q    <= '0;
			valid_s2  <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			long_q    <= long_n;
			idx_q     <= idx_n;
			seq_q     <= seq_n;
			comp_ok_q <= comp_ok_n;
			crc_q     <= crc_n;
			crc_hi_q  <= crc_hi_n;
			idle_q    <= idle_n;
			if (advance)
				valid_s2 <= item_take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take && emit) begin
			res_s2 <= res_n;
		end
	end

endmodule

// ----- hw/rtl/ymodem_packet_receiver.sv -----
// YMODEM packet receiver top level
//
// Input channel (in_valid/in_ready): one transaction is either a received
// byte (action 0, rx_byte) or one timer tick (action 1).
// Output channel (out_valid/out_ready): payload bytes as they arrive, then
// one status per packet (good, EOT, cancel, abort, error). Drop the payload
// of any packet whose status is not good.
// Config channel (cfg_valid/cfg_ready): writes timeout_ticks; write only
// while no transaction is in flight. cfg_ready is always high.
// A taken input transaction is held in the input register, its result in
// the result register. Throughput: one input transaction per cycle while
// the output is not stalled, set by the input register and the result
// register around the framing logic. A stalled output holds its result and
// backs up the input stage; in_ready drops once the input register is full.
// Reset: waiting for a header, timeout_ticks back to 1000, no result held.
module ymodem_packet_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  data_byte,
	output logic [2:0]  status,
	output logic [7:0]  seq_number,
	output logic [10:0] payload_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] timeout_ticks
);
	import ymp_pkg::*;

	item_t       in_item, item;
	logic        item_valid, item_take;
	result_t     result;
	logic [15:0] timeout_q;

	assign in_item.action  = action;
	assign in_item.rx_byte = rx_byte;
	assign cfg_ready       = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= timeout_ticks;
		end
	end

	ymp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	ymp_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.timeout    (timeout_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result)
	);

	assign result_kind    = result.kind;
	assign data_byte      = result.data;
	assign status         = result.status;
	assign seq_number     = result.seq;
	assign payload_length = result.len;

endmodule

// ----- hw/rtl/ymp_checker.sv -----
// Port-level checks for the YMODEM receiver, bound to the top level
`include "ymodem_packet_receiver_assert.svh"

module ymp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        result_kind,
	input logic [7:0]  data_byte,
	input logic [2:0]  status,
	input logic [7:0]  seq_number,
	input logic [10:0] payload_length
);
	import ymp_pkg::*;

	`YMP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(result_kind) && $stable(data_byte) && $stable(status) &&
		$stable(seq_number) && $stable(payload_length))

	`YMP_ASSERT_NOW(a_data_clean, out_valid && result_kind == KIND_DATA,
		status == ST_GOOD && seq_number == 8'd0 && payload_length == 11'd0)

	`YMP_ASSERT_NOW(a_good_len, out_valid && result_kind == KIND_STATUS && status == ST_GOOD,
		data_byte == 8'd0 && (payload_length == LEN_SHORT || payload_length == LEN_LONG))

	`YMP_ASSERT_NOW(a_bad_empty, out_valid && result_kind == KIND_STATUS && status != ST_GOOD,
		data_byte == 8'd0 && seq_number == 8'd0 && payload_length == 11'd0)

endmodule

bind ymodem_packet_receiver ymp_checker u_ymp_checker (.*);
